@@ src/bks_pkg.sv @@
// Package for the bounded key set: operation codes, stream widths and the
// control bundle that the top level drives into every cell of the chain.
// No dependencies.
`default_nettype none

package bks_pkg;

  // Operation codes carried in the low bits of the request.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Field widths fixed by the stream format.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 8;

  // Control that goes to every cell at once.
  typedef struct packed {
    logic cmp_en;  // capture the match of the broadcast key
    logic add_en;  // the tail cell stores the broadcast key
    logic rem_en;  // cells at or above the hit take their upper neighbor's key
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/bounded_key_set.sv @@
// Bounded key set: a chain of key cells with parallel compare. Depends on bks_pkg, bks_cell.
// For each request, the accept edge captures every cell's match and a later
// edge in the apply state updates the chain and loads the result register.
// A new request is taken only once the previous one has been applied; the apply
// step waits only while an older result still waits on out_tready.
// Reset (synchronous, rst_n low) empties the set, drops any pending result and holds off input.
`default_nettype none

module bounded_key_set #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [bks_pkg::IN_W-1:0]     in_tdata,   // [1:0] operation, [33:2] key
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [bks_pkg::OUT_W-1:0]    out_tdata   // [0] was_member, [1] status,
                                                   // [6:2] element_count
);

  // Only the low KEY_WIDTH bits of the key take part; the key field itself
  // is 32 bits wide, so a wider setting stores nothing more.
  localparam int unsigned STORE_W = (KEY_WIDTH < bks_pkg::KEY_W) ? KEY_WIDTH
                                                                 : bks_pkg::KEY_W;
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);

  // The block alternates between taking a request and applying it.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic [bks_pkg::OP_W-1:0] op_r, op_nxt;
  logic [STORE_W-1:0]       key_r, key_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [bks_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic [bks_pkg::KEY_W-1:0] in_key;
  logic [STORE_W-1:0]        key_bcast;
  logic                      accept;
  logic                      can_apply;
  logic                      present;
  logic                      full;
  logic                      status;
  bks_pkg::cell_ctrl_t       ctrl;

  logic [CAPACITY:0]         hit;
  logic [STORE_W-1:0]        cell_key [CAPACITY];
  logic [CAPACITY-1:0]       occ;
  logic [CAPACITY-1:0]       tail;

  logic [CNT_W+4:0]                cnt_wide;
  logic [bks_pkg::COUNT_W-1:0]     elem_count;

  assign in_key    = in_tdata[bks_pkg::OP_W +: bks_pkg::KEY_W];
  // No request is taken while reset is held.
  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // The apply step waits only while an older result is still held.
  assign can_apply = (state_r == ST_APPLY) && (!out_valid_r || out_tready);

  // During the accept cycle the cells see the incoming key; afterwards they
  // see the latched one, which an add stores into the tail cell.
  assign key_bcast = in_tready ? in_key[STORE_W-1:0] : key_r;

  // A match anywhere in the chain ends up on the last hit signal.
  assign present = hit[CAPACITY];
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign status  = (op_r == bks_pkg::OP_ADD) && !present && full;

  assign ctrl.cmp_en = accept;
  assign ctrl.add_en = can_apply && (op_r == bks_pkg::OP_ADD) && !present && !full;
  assign ctrl.rem_en = can_apply && (op_r == bks_pkg::OP_REMOVE) && present;

  assign hit[0] = 1'b0;

  // The chain: cell i holds the i-th oldest key. On a remove, every cell at or
  // above the matching one takes the key of its upper neighbor, closing the gap.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i]  = (CNT_W'(i) < count_r);
    assign tail[i] = (CNT_W'(i) == count_r);

    if (i == CAPACITY - 1) begin : g_last
      bks_cell #(.STORE_W(STORE_W)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .key_bcast  (key_bcast),
        .occ_in     (occ[i]),
        .tail_in    (tail[i]),
        .hit_in     (hit[i]),
        .nbr_key_in (cell_key[i]),
        .hit_out    (hit[i+1]),
        .key_out    (cell_key[i])
      );
    end else begin : g_mid
      bks_cell #(.STORE_W(STORE_W)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .key_bcast  (key_bcast),
        .occ_in     (occ[i]),
        .tail_in    (tail[i]),
        .hit_in     (hit[i]),
        .nbr_key_in (cell_key[i+1]),
        .hit_out    (hit[i+1]),
        .key_out    (cell_key[i])
      );
    end
  end

  // Element count after the operation, shown modulo 32.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.add_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.rem_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign cnt_wide   = (CNT_W + 5)'(count_nxt);
  assign elem_count = cnt_wide[bks_pkg::COUNT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_tdata[bks_pkg::OP_W-1:0];
          key_nxt   = in_key[STORE_W-1:0];
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (can_apply) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, elem_count, status, present};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ src/bks_cell.sv @@
// One cell of the key chain: holds one key, compares it with the broadcast
// key and passes its key down to the cell below on a remove.
// Depends on bks_pkg.
`default_nettype none

module bks_cell #(
  parameter int unsigned STORE_W = 32
) (
  input  wire                     clk,
  input  wire bks_pkg::cell_ctrl_t ctrl,
  input  wire  [STORE_W-1:0]      key_bcast,   // key under test or to be stored
  input  wire                     occ_in,      // this cell holds a valid key
  input  wire                     tail_in,     // this cell is the first free one
  input  wire                     hit_in,      // a cell below matched
  input  wire  [STORE_W-1:0]      nbr_key_in,  // key of the cell above
  output logic                    hit_out,
  output logic [STORE_W-1:0]      key_out
);

  logic [STORE_W-1:0] key_r;
  logic [STORE_W-1:0] key_nxt;
  logic               match_r;
  logic               match_nxt;

  assign hit_out = hit_in | match_r;
  assign key_out = key_r;

  always_comb begin
    match_nxt = match_r;
    if (ctrl.cmp_en) begin
      match_nxt = occ_in && (key_r == key_bcast);
    end
  end

  always_comb begin
    key_nxt = key_r;
    if (ctrl.add_en && tail_in) begin
      key_nxt = key_bcast;
    end else if (ctrl.rem_en && hit_out) begin
      key_nxt = nbr_key_in;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    match_r <= match_nxt;
  end

endmodule

`default_nettype wire

@@ src/bks_checker.sv @@
// Port-level checks for the bounded key set, bound to the top level.
// Depends on bounded_key_set.
`default_nettype none

module bks_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire       clk,
  input wire       rst_n,
  input wire       in_tvalid,
  input wire       in_tready,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata
);

  // A held result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Each request occupies the block for its apply cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted in back-to-back cycles");

  // A refused add never concerns a present key and only happens when full.
  a_refuse_not_member: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0] && (out_tdata[6:2] == 5'(CAPACITY)))
    else $error("refused add with inconsistent result");

  // The count never exceeds the capacity; the check is skipped for capacities above 31.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CAPACITY > 31) || (out_tdata[6:2] <= 5'(CAPACITY)))
    else $error("element count beyond capacity");

  // No result appears in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind bounded_key_set bks_checker #(.CAPACITY(CAPACITY)) u_bks_checker (.*);

`default_nettype wire

@@ verif/tb_bounded_key_set.sv @@
// Self-checking testbench for the bounded key set: directed and random
// add/remove/lookup requests, checked against a queue-based model of the set.
// Depends on bks_pkg and the bounded_key_set top level.
`timescale 1ns / 100ps

module tb_bounded_key_set;

  localparam int unsigned SET_CAPACITY = 16;
  localparam int unsigned SET_KEY_W    = 32;

  // Code 3 has no name in the package; the block treats it as a lookup.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int RANDOM_REQUESTS = 1600;
  localparam int PHASE_LEN       = 80;
  localparam int POOL_SIZE       = 24;
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int HOLD_AFTER      = 500;   // replies seen before the hold-off starts
  localparam int STALL_LIMIT     = 2000;  // cycles without any handshake
  localparam int DRAIN_CYCLES    = 8;
  localparam int PRINT_CAP       = 20;

  // One reply, unpacked field by field from out_tdata.
  typedef struct packed {
    logic       was_member;
    logic       status;
    logic [4:0] count;
  } reply_t;

  // One row of the directed table. When has_want is set, the expected reply
  // is typed in; otherwise it comes from the set model.
  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    bit          has_want;
    reply_t      want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  wire                       in_tready;
  logic [bks_pkg::IN_W-1:0]  in_tdata = '0;    // [1:0] operation, [33:2] key, [39:34] zero
  wire                       out_tvalid;
  logic                      out_tready = 1'b0;
  wire  [bks_pkg::OUT_W-1:0] out_tdata;        // [0] was_member, [1] status,
                                               // [6:2] element_count, [7] zero

  bounded_key_set #(
    .CAPACITY (SET_CAPACITY),
    .KEY_WIDTH(SET_KEY_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Model of the set: keys in insertion order, exactly as the chain holds them.
  logic [31:0] held_keys[$];
  reply_t      pending_replies[$];

  int error_count     = 0;
  int requests_sent   = 0;
  int replies_checked = 0;
  int full_refusals   = 0;
  int removes_hit     = 0;
  int times_full      = 0;
  int idle_cycles     = 0;
  int burst_left      = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Applies one request to the model and returns the reply it should produce.
  function automatic reply_t apply_to_set(input logic [1:0] op, input logic [31:0] key);
    int     hit;
    int     n;
    reply_t r;
    hit = -1;
    foreach (held_keys[i])
      if (hit < 0 && held_keys[i] == key)
        hit = i;
    r.was_member = (hit >= 0);
    r.status = 1'b0;
    case (op)
      bks_pkg::OP_ADD: begin
        if (hit < 0) begin
          if (held_keys.size() < SET_CAPACITY) begin
            held_keys.insert(held_keys.size(), key);
          end else begin
            r.status = 1'b1;
            full_refusals++;
          end
        end
      end
      bks_pkg::OP_REMOVE: begin
        if (hit >= 0) begin
          held_keys.delete(hit);
          removes_hit++;
        end
      end
      default: begin
      end
    endcase
    n = held_keys.size();
    if (n == SET_CAPACITY)
      times_full++;
    r.count = n[4:0];
    return r;
  endfunction

  function automatic stim_row_t row(input logic [1:0] op, input logic [31:0] key,
                                    input bit has_want, input logic wm,
                                    input logic st, input logic [4:0] cnt);
    stim_row_t s;
    s.op = op;
    s.key = key;
    s.has_want = has_want;
    s.want.was_member = wm;
    s.want.status = st;
    s.want.count = cnt;
    return s;
  endfunction

  // Offers one request and returns at the edge where it is accepted. The
  // sender works in bursts: when a burst runs out, valid may drop for a random
  // gap. in_tready is sampled at the falling edge, where it is settled for
  // the coming rising edge.
  task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                              input reply_t want, input bit has_want);
    int     gap;
    bit     taken;
    reply_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, key, op};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    predicted = apply_to_set(op, key);
    pending_replies.insert(pending_replies.size(), has_want ? want : predicted);
    requests_sent++;
  endtask

  // Receiver: the ready pattern picks a new random mode for each phase, and once, after
  // enough replies, it holds off long enough for the block to fill and stall
  // its input while the sender keeps offering.
  initial begin : receiver
    int  mode;
    int  phase_cycles;
    bit  hold_done;
    mode = 0;
    phase_cycles = 0;
    hold_done = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!hold_done && replies_checked >= HOLD_AFTER) begin
        hold_done = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (phase_cycles == 0) begin
          mode = $urandom_range(0, 3);
          phase_cycles = 64;
        end
        phase_cycles--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (phase_cycles % 8) < 5;
        endcase
      end
    end
  end

  // Reply checker and watchdog, both sampled at the falling edge so that the
  // handshake seen here is the one that completes at the next rising edge.
  always @(negedge clk) begin : reply_monitor
    reply_t got;
    reply_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.was_member = out_tdata[0];
        got.status     = out_tdata[1];
        got.count      = out_tdata[6:2];
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("reply 0x%02h with no request outstanding", out_tdata));
        end else begin
          want = pending_replies.pop_front();
          if (got.was_member !== want.was_member)
            report_mismatch($sformatf("reply %0d was_member %b, expected %b",
                                      replies_checked, got.was_member, want.was_member));
          if (got.status !== want.status)
            report_mismatch($sformatf("reply %0d status %b, expected %b",
                                      replies_checked, got.status, want.status));
          if (got.count !== want.count)
            report_mismatch($sformatf("reply %0d element_count %0d, expected %0d",
                                      replies_checked, got.count, want.count));
          if (out_tdata[7] !== 1'b0)
            report_mismatch($sformatf("reply %0d padding bit is %b",
                                      replies_checked, out_tdata[7]));
        end
        replies_checked++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d replies outstanding",
                 STALL_LIMIT, pending_replies.size());
        $display("tb_bounded_key_set: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t   directed[$];
    logic [31:0] key_pool[POOL_SIZE];
    logic [1:0]  op;
    logic [31:0] key;
    int          bias;
    int          pick;
    reply_t      none;

    none = '0;
    foreach (key_pool[i])
      key_pool[i] = $urandom;

    // Directed table: empty-set behavior, duplicate add, the all-ones key,
    // filling to capacity with single-bit keys, a refused add when full,
    // removal of the first entry so the rest close up, and the spare code.
    directed = {directed, row(bks_pkg::OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd0)};
    directed = {directed, row(bks_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 5'd0)};
    directed = {directed, row(OP_SPARE,           32'h5555_5555, 1'b1, 1'b0, 1'b0, 5'd0)};
    directed = {directed, row(bks_pkg::OP_ADD,    32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd1)};
    directed = {directed, row(bks_pkg::OP_ADD,    32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd1)};
    directed = {directed, row(bks_pkg::OP_ADD,    32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 5'd2)};
    for (int i = 0; i < SET_CAPACITY - 2; i++)
      directed = {directed, row(bks_pkg::OP_ADD, 32'h1 << (2 * i + 1),
                                1'b0, 1'b0, 1'b0, 5'd0)};
    directed = {directed, row(bks_pkg::OP_ADD,    32'hA5A5_A5A5, 1'b1, 1'b0, 1'b1, 5'd16)};
    directed = {directed, row(bks_pkg::OP_ADD,    32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd16)};
    directed = {directed, row(bks_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd15)};
    directed = {directed, row(bks_pkg::OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd15)};
    directed = {directed, row(OP_SPARE,           32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 5'd15)};
    directed = {directed, row(bks_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 5'd14)};

    // Reset is held low from the start and released at a rising edge.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_request(directed[i].op, directed[i].key, directed[i].want, directed[i].has_want);

    // Random part. Keys come mostly from a small pool so that adds, removes
    // and lookups keep hitting the same entries and the set runs full and
    // empty; a few fully random keys add noise. Each phase leans toward
    // filling, draining or a mix, and refreshes part of the pool.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % PHASE_LEN == 0) begin
        bias = $urandom_range(0, 2);
        repeat (4) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      end
      pick = $urandom_range(0, 99);
      case (bias)
        0:       op = (pick < 60) ? bks_pkg::OP_ADD : (pick < 75) ? bks_pkg::OP_REMOVE :
                      (pick < 92) ? bks_pkg::OP_LOOKUP : OP_SPARE;
        1:       op = (pick < 15) ? bks_pkg::OP_ADD : (pick < 75) ? bks_pkg::OP_REMOVE :
                      (pick < 92) ? bks_pkg::OP_LOOKUP : OP_SPARE;
        default: op = (pick < 38) ? bks_pkg::OP_ADD : (pick < 70) ? bks_pkg::OP_REMOVE :
                      (pick < 92) ? bks_pkg::OP_LOOKUP : OP_SPARE;
      endcase
      if ($urandom_range(0, 99) < 85)
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        key = $urandom;
      send_request(op, key, none, 1'b0);
    end
    in_tvalid <= 1'b0;

    while (pending_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));

    $display("Covered %0d requests and %0d replies: %0d adds refused on a full set,",
             requests_sent, replies_checked, full_refusals);
    $display("%0d removes of present keys, %0d replies with the set at capacity.",
             removes_hit, times_full);
    if (error_count == 0)
      $display("tb_bounded_key_set: done, clean");
    else
      $display("tb_bounded_key_set: done, errors");
    $finish;
  end

endmodule
